// ===== src/flow_stats_hash_table_top_defines.svh =====
// Assertion macros for the flow statistics table checker.
// Used by the checker file only.
`ifndef FLOW_STATS_HASH_TABLE_TOP_DEFINES_SVH
`define FLOW_STATS_HASH_TABLE_TOP_DEFINES_SVH
// check a property every clock outside reset
`define FST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check a property every clock, reset included
`define FST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`endif

// ===== src/fst_pkg.sv =====
// Package for the flow statistics table: types, constants, result codes.
// No dependencies.
`default_nettype none
package fst_pkg;
   localparam logic [31:0] HASH_SEED  = 32'h7135efee;
   localparam logic [63:0] MARK_MAGIC = 64'd8386112020297315432;

   typedef enum logic [1:0] {
      OUT_UNMARKED = 2'd0,
      OUT_INSERTED = 2'd1,
      OUT_UPDATED  = 2'd2,
      OUT_DROPPED  = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] udp_sport;
      logic [15:0] udp_dport;
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
   } key_type;

   // one table slot as stored in memory
   typedef struct packed {
      logic [31:0] hash;
      key_type     key;
      logic [63:0] max_seq;
      logic [63:0] packets;
   } entry_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
      rotl = (x << r) | (x >> (32 - r));
   endfunction

   // lookup3 word: four wire bytes, first byte least significant
   function automatic logic [31:0] wswap(input logic [31:0] be);
      wswap = {be[7:0], be[15:8], be[23:16], be[31:24]};
   endfunction
endpackage
`default_nettype wire

// ===== src/flow_stats_hash_table_top.sv =====
// Top level of the flow statistics table: probe sequencer, used bits, output register.
// Depends on fst_pkg, fst_hash, fst_table.
//
//  channel | dir | beat contents
//  req_    | in  | tdata: src_ip, dst_ip, udp_sport, udp_dport, src_mac, dst_mac, magic, seq
//  rsp_    | out | tdata: outcome, slot, stream_max_seq, stream_packets
//
// Unmarked beat: result state, then idle. Marked beat: hash, then per probe a read
// state and a compare-and-write-back state, then the result and idle states;
// a full table walks all slots. A stall on rsp_tready holds the result state.
// Reset clears the used bit of every slot at once; no clearing pass.
// One beat is in work at a time; the result register holds while rsp_tready is low.
`default_nettype none
module flow_stats_hash_table_top #(
   parameter int TABLE_SLOTS = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // src_ip[31:0] dst_ip[63:32] udp_sport[79:64] udp_dport[95:80] src_mac[143:96]
   // dst_mac[191:144] marker_magic[255:192] seq_number[319:256]
   input  wire logic [319:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // outcome[1:0] slot[7:2] stream_max_seq[71:8] stream_packets[135:72], zero pad
   output logic [143:0]      rsp_tdata
);
   import fst_pkg::*;

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int CW = $clog2(TABLE_SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_HASH, S_READ, S_CHECK, S_RESP
   } state_type;

   state_type           state_ff;
   key_type             key_ff;
   logic [63:0]         seq_ff;
   logic [31:0]         hash_ff;
   logic [AW-1:0]       probe_ff;
   logic [CW-1:0]       count_ff;
   logic [TABLE_SLOTS-1:0] used_ff;
   logic [143:0]        rsp_ff;
   logic                hash_start, hash_done;
   logic [31:0]         hash_val;
   entry_type           rd_data, wr_data;
   logic                wr_en;
   logic                match;
   logic [63:0]         new_max, new_cnt;
   logic [5:0]          slot6;
   key_type             in_key;
   logic                accept;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign in_key = '{src_ip: req_tdata[31:0], dst_ip: req_tdata[63:32],
                     udp_sport: req_tdata[79:64], udp_dport: req_tdata[95:80],
                     src_mac: req_tdata[143:96], dst_mac: req_tdata[191:144]};
   assign hash_start = accept && (req_tdata[255:192] == MARK_MAGIC);

   fst_hash u_hash (
      .clock(clock), .reset(reset), .start(hash_start), .key(in_key),
      .done(hash_done), .hash(hash_val)
   );

   fst_table #(.SLOTS(TABLE_SLOTS)) u_table (
      .clock(clock), .rd_addr(probe_ff), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(probe_ff), .wr_data(wr_data)
   );

   assign match = (rd_data.hash == hash_ff) && (rd_data.key == key_ff);
   always_comb begin
      if (!used_ff[probe_ff]) begin
         new_max = seq_ff;
         new_cnt = 64'd1;
      end else begin
         new_max = (seq_ff > rd_data.max_seq) ? seq_ff : rd_data.max_seq;
         new_cnt = rd_data.packets + 64'd1;
      end
   end
   assign wr_data = '{hash: hash_ff, key: key_ff, max_seq: new_max, packets: new_cnt};
   assign wr_en = (state_ff == S_CHECK) && (!used_ff[probe_ff] || match);
   assign slot6 = 6'(probe_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (accept) begin
               key_ff <= in_key;
               seq_ff <= req_tdata[319:256];
               if (hash_start) state_ff <= S_HASH;
               else begin
                  rsp_ff   <= {142'd0, OUT_UNMARKED};
                  state_ff <= S_RESP;
               end
            end
            S_HASH: if (hash_done) begin
               hash_ff  <= hash_val;
               probe_ff <= AW'(hash_val % TABLE_SLOTS);
               count_ff <= '0;
               state_ff <= S_READ;
            end
            S_READ: state_ff <= S_CHECK;
            S_CHECK: begin
               if (wr_en) begin
                  used_ff[probe_ff] <= 1'b1;
                  rsp_ff <= {8'd0, new_cnt, new_max, slot6,
                             used_ff[probe_ff] ? OUT_UPDATED : OUT_INSERTED};
                  state_ff <= S_RESP;
               end else if (count_ff == CW'(TABLE_SLOTS - 1)) begin
                  rsp_ff   <= {142'd0, OUT_DROPPED};
                  state_ff <= S_RESP;
               end else begin
                  count_ff <= count_ff + CW'(1);
                  probe_ff <= (probe_ff == AW'(TABLE_SLOTS - 1)) ? '0 : probe_ff + AW'(1);
                  state_ff <= S_READ;
               end
            end
            S_RESP: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = rsp_ff;
endmodule
`default_nettype wire

// ===== src/fst_hash.sv =====
// lookup3 hash over the 24 byte flow key, one mixing round per cycle.
// Depends on fst_pkg.
`default_nettype none
module fst_hash (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire fst_pkg::key_type key,
   output logic                  done,
   output logic [31:0]           hash
);
   import fst_pkg::*;

   logic [31:0] a_ff, b_ff, c_ff, a_in, b_in, c_in;
   logic [3:0]  step_ff, step_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   key_type     key_ff, key_in;
   logic [31:0] w [6];
   logic [31:0] iv;

   // key is captured on start; later rounds use the held copy
   assign key_in = start ? key : key_ff;

   assign iv = 32'hdeadbeef + 32'd24 + HASH_SEED;
   assign w[0] = wswap(key_in.src_ip);
   assign w[1] = wswap(key_in.dst_ip);
   assign w[2] = wswap({key_in.udp_sport, key_in.udp_dport});
   assign w[3] = wswap(key_in.src_mac[47:16]);
   assign w[4] = wswap({key_in.src_mac[15:0], key_in.dst_mac[47:32]});
   assign w[5] = wswap(key_in.dst_mac[31:0]);

   always_comb begin
      a_in = a_ff; b_in = b_ff; c_in = c_ff;
      step_in = step_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         a_in = iv + w[0]; b_in = iv + w[1]; c_in = iv + w[2];
         step_in = 4'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 4'd1;
         case (step_ff)
            4'd0: begin a_in = (a_ff - c_ff) ^ rotl(c_ff, 4);  c_in = c_ff + b_ff; end
            4'd1: begin b_in = (b_ff - a_ff) ^ rotl(a_ff, 6);  a_in = a_ff + c_ff; end
            4'd2: begin c_in = (c_ff - b_ff) ^ rotl(b_ff, 8);  b_in = b_ff + a_ff; end
            4'd3: begin a_in = (a_ff - c_ff) ^ rotl(c_ff, 16); c_in = c_ff + b_ff; end
            4'd4: begin b_in = (b_ff - a_ff) ^ rotl(a_ff, 19); a_in = a_ff + c_ff; end
            4'd5: begin
               c_in = (c_ff - b_ff) ^ rotl(b_ff, 4);
               b_in = b_ff + a_ff + w[4];
               a_in = a_ff + w[3];
            end
            4'd6: c_in = c_ff + w[5];
            4'd7:  c_in = (c_ff ^ b_ff) - rotl(b_ff, 14);
            4'd8:  a_in = (a_ff ^ c_ff) - rotl(c_ff, 11);
            4'd9:  b_in = (b_ff ^ a_ff) - rotl(a_ff, 25);
            4'd10: c_in = (c_ff ^ b_ff) - rotl(b_ff, 16);
            4'd11: a_in = (a_ff ^ c_ff) - rotl(c_ff, 4);
            4'd12: b_in = (b_ff ^ a_ff) - rotl(a_ff, 14);
            4'd13: begin
               c_in = (c_ff ^ b_ff) - rotl(b_ff, 24);
               busy_in = 1'b0; done_in = 1'b1;
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; step_ff <= step_in;
      key_ff <= key_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign hash = c_ff;
endmodule
`default_nettype wire

// ===== src/fst_table.sv =====
// Slot memory with one read and one write port; the read data is registered.
// Depends on fst_pkg.
`default_nettype none
module fst_table #(
   parameter int SLOTS = 64
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
   output fst_pkg::entry_type            rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
   input  wire fst_pkg::entry_type       wr_data
);
   import fst_pkg::*;

   entry_type mem [SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== src/fst_checker.sv =====
// Port-level checks for flow_stats_hash_table_top, bound to it below.
// Depends on flow_stats_hash_table_top_defines.svh and fst_pkg.
`include "flow_stats_hash_table_top_defines.svh"
`default_nettype none
module fst_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [143:0] rsp_tdata
);
   import fst_pkg::*;

   `FST_ASSERT(rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp beat dropped or changed")
   `FST_ASSERT(one_in_flight, rsp_tvalid |-> !req_tready, "request taken while result pending")
   `FST_ASSERT(drop_zero, rsp_tvalid && rsp_tdata[1:0] == OUT_DROPPED |-> rsp_tdata[135:2] == '0, "drop carries data")
   `FST_ASSERT(unmarked_zero, rsp_tvalid && rsp_tdata[1:0] == OUT_UNMARKED |-> rsp_tdata[135:2] == '0, "unmarked carries data")
   `FST_ASSERT_ALWAYS(reset_idle, reset |=> !rsp_tvalid, "result valid after reset")
endmodule

bind flow_stats_hash_table_top fst_checker u_fst_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire
